// ===== hdl/mmu_clock_page_replacement_unit_macros.svh =====
// Assertion macros shared by the page replacement unit RTL.
// Depends on nothing; expects a clock named clk and a reset named rst in scope.
`ifndef MMU_CLOCK_PAGE_REPLACEMENT_UNIT_MACROS_SVH
`define MMU_CLOCK_PAGE_REPLACEMENT_UNIT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define MMU_CLK_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define MMU_CLK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MMU_CLK_ASSERT_NOW(lbl, ante, cons, msg)
`define MMU_CLK_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hdl/mmu_clk_pkg.sv =====
// Shared types and constants for the clock page replacement unit.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps
`default_nettype none

package mmu_clk_pkg;

  localparam int MAX_PAGES  = 256;
  localparam int MAX_FRAMES = 64;

  localparam int ADDR_W     = 32;
  localparam int PAGE_W     = $clog2(MAX_PAGES);
  localparam int FRAME_W    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int FCNT_W     = $clog2(MAX_FRAMES + 1);
  localparam int VICTIM_W   = 8;

  localparam int SHIFT_W    = 5;
  localparam int NPAGES_W   = 9;
  localparam int NFRAMES_W  = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int OUT_TDATA_W = 48;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_PAGES  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_FRAMES = 2'd2;

  localparam logic [SHIFT_W-1:0]   PAGE_SHIFT_RST = 5'd12;
  localparam logic [NPAGES_W-1:0]  NUM_PAGES_RST  = 9'd256;
  localparam logic [NFRAMES_W-1:0] NUM_FRAMES_RST = 7'd64;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_CHECK,
    S_OWN,
    S_PTRD,
    S_TEST,
    S_INSTALL,
    S_DONE
  } mmu_state_t;

  // page table entry kept in RAM; presence lives in flops
  typedef struct packed {
    logic               referenced;
    logic               modified;
    logic [FRAME_W-1:0] frame;
  } pte_t;

  typedef struct packed {
    logic accept;       // latch the input transaction
    logic lookup;       // decode page, read its entry
    logic hit_upd;      // resident page: update ref/mod
    logic alloc;        // fault with a free frame
    logic hand_wrap;    // fault, start of sweep
    logic pt_rd_owner;  // read the entry of the frame's owner
    logic sweep_clear;  // second chance: clear ref, advance hand
    logic sweep_evict;  // victim found
    logic install;      // map faulting page into chosen frame
    logic load_out;     // move result into output register
  } mmu_cmd_t;

  typedef struct packed {
    logic illegal;
    logic present;
    logic referenced;
    logic free_avail;
    logic out_busy;
  } mmu_status_t;

endpackage

`default_nettype wire

// ===== hdl/mmu_clk_ctrl.sv =====
// Sequencer for the clock page replacement unit.
// Depends on mmu_clk_pkg; drives the datapath through mmu_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module mmu_clk_ctrl
  import mmu_clk_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire mmu_status_t st,
  output mmu_cmd_t         cmd
);

  mmu_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_LOOKUP;
      end
      S_LOOKUP: state_next = S_CHECK;
      S_CHECK: begin
        if (st.illegal || st.present) state_next = S_DONE;
        else if (st.free_avail)       state_next = S_INSTALL;
        else                          state_next = S_OWN;
      end
      S_OWN:  state_next = S_PTRD;
      S_PTRD: state_next = S_TEST;
      S_TEST: begin
        if (st.referenced) state_next = S_OWN;
        else               state_next = S_INSTALL;
      end
      S_INSTALL: state_next = S_DONE;
      S_DONE: begin
        if (!st.out_busy) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      S_LOOKUP: cmd.lookup = 1'b1;
      S_CHECK: begin
        if (!st.illegal) begin
          if (st.present)         cmd.hit_upd   = 1'b1;
          else if (st.free_avail) cmd.alloc     = 1'b1;
          else                    cmd.hand_wrap = 1'b1;
        end
      end
      S_OWN:  ;
      S_PTRD: cmd.pt_rd_owner = 1'b1;
      S_TEST: begin
        if (st.referenced) cmd.sweep_clear = 1'b1;
        else               cmd.sweep_evict = 1'b1;
      end
      S_INSTALL: cmd.install = 1'b1;
      S_DONE:    cmd.load_out = !st.out_busy;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/mmu_clk_dp.sv =====
// Datapath of the clock page replacement unit: config registers, page table,
// frame owner RAM, clock hand, free counter, result register. Uses mmu_clk_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "mmu_clock_page_replacement_unit_macros.svh"

module mmu_clk_dp
  import mmu_clk_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_addr,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_func,
  input  wire logic [ADDR_W-1:0]      in_va,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [OUT_TDATA_W-1:0]      out_data,
  input  wire mmu_cmd_t               cmd,
  output mmu_status_t                 st
);

  // configuration
  logic [SHIFT_W-1:0]   page_shift;
  logic [NPAGES_W-1:0]  num_pages;
  logic [NFRAMES_W-1:0] num_frames;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_shift <= PAGE_SHIFT_RST;
      num_pages  <= NUM_PAGES_RST;
      num_frames <= NUM_FRAMES_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_PAGE_SHIFT: page_shift <= cfg_data[SHIFT_W-1:0];
        CFG_NUM_PAGES:  num_pages  <= cfg_data[NPAGES_W-1:0];
        CFG_NUM_FRAMES: num_frames <= cfg_data[NFRAMES_W-1:0];
        default: ;
      endcase
    end
  end

  // effective frame count: zero acts as one, saturate at MAX_FRAMES
  logic [FCNT_W-1:0] nf;
  always_comb begin
    if (num_frames == '0)
      nf = FCNT_W'(1);
    else if (32'(num_frames) > 32'(MAX_FRAMES))
      nf = FCNT_W'(MAX_FRAMES);
    else
      nf = FCNT_W'(num_frames);
  end

  // transaction working registers
  logic               func_q;
  logic [ADDR_W-1:0]  va_q;
  logic [PAGE_W-1:0]  page_q;
  logic               illegal_q;
  logic               fault_q;
  logic               evicted_q;
  logic               wb_q;
  logic [PAGE_W-1:0]  victim_q;
  logic [FRAME_W-1:0] frame_q;
  logic [PAGE_W-1:0]  own_q;

  logic [ADDR_W-1:0]  page_full;
  logic               illegal_c;
  assign page_full = va_q >> page_shift;
  assign illegal_c = (page_full >= 32'(num_pages)) || (page_full >= 32'(MAX_PAGES));

  // page table: presence in flops, rest in RAM
  logic [MAX_PAGES-1:0] present;
  pte_t                 pt_mem [MAX_PAGES];
  pte_t                 pt_rd;
  logic                 pres_rd;
  pte_t                 pte_rd;
  logic [PAGE_W-1:0]    pt_raddr;
  logic                 pt_we;
  logic [PAGE_W-1:0]    pt_waddr;
  pte_t                 pt_wdata;

  // frame owner RAM, read at the clock hand
  logic [PAGE_W-1:0]    fo_mem [MAX_FRAMES];
  logic [PAGE_W-1:0]    own_rd;

  logic [FRAME_W-1:0]   hand_q;
  logic [FCNT_W-1:0]    next_free;
  logic [FCNT_W-1:0]    hand_inc;
  logic [FRAME_W-1:0]   hand_adv;

  assign pt_raddr = cmd.pt_rd_owner ? own_rd : page_full[PAGE_W-1:0];
  assign pte_rd   = pres_rd ? pt_rd : '0;

  always_comb begin
    pt_we    = 1'b0;
    pt_waddr = page_q;
    pt_wdata = '0;
    if (cmd.hit_upd) begin
      pt_we               = 1'b1;
      pt_wdata.referenced = 1'b1;
      pt_wdata.modified   = pte_rd.modified | func_q;
      pt_wdata.frame      = pte_rd.frame;
    end else if (cmd.sweep_clear) begin
      pt_we               = 1'b1;
      pt_waddr            = own_q;
      pt_wdata.referenced = 1'b0;
      pt_wdata.modified   = pte_rd.modified;
      pt_wdata.frame      = pte_rd.frame;
    end else if (cmd.install) begin
      pt_we               = 1'b1;
      pt_wdata.referenced = 1'b1;
      pt_wdata.modified   = func_q;
      pt_wdata.frame      = frame_q;
    end
  end

  always_ff @(posedge clk) begin
    if (pt_we) pt_mem[pt_waddr] <= pt_wdata;
    pt_rd   <= pt_mem[pt_raddr];
    pres_rd <= present[pt_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present <= '0;
    end else begin
      if (cmd.sweep_evict) present[own_q]  <= 1'b0;
      if (cmd.install)     present[page_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.install) fo_mem[frame_q] <= page_q;
    own_rd <= fo_mem[hand_q];
  end

  // clock hand and free frame counter
  assign hand_inc = FCNT_W'(hand_q) + FCNT_W'(1);
  assign hand_adv = (hand_inc >= nf) ? '0 : hand_inc[FRAME_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      hand_q    <= '0;
      next_free <= '0;
    end else begin
      if (cmd.alloc) next_free <= next_free + FCNT_W'(1);
      if (cmd.hand_wrap && (FCNT_W'(hand_q) >= nf)) hand_q <= '0;
      if (cmd.sweep_clear || cmd.sweep_evict)       hand_q <= hand_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_q    <= in_func;
      va_q      <= in_va;
      fault_q   <= 1'b0;
      evicted_q <= 1'b0;
      wb_q      <= 1'b0;
      victim_q  <= '0;
    end
    if (cmd.lookup) begin
      page_q    <= page_full[PAGE_W-1:0];
      illegal_q <= illegal_c;
    end
    if (cmd.hit_upd) frame_q <= pte_rd.frame;
    if (cmd.alloc) begin
      frame_q <= next_free[FRAME_W-1:0];
      fault_q <= 1'b1;
    end
    if (cmd.hand_wrap)   fault_q <= 1'b1;
    if (cmd.pt_rd_owner) own_q   <= own_rd;
    if (cmd.sweep_evict) begin
      frame_q   <= hand_q;
      victim_q  <= own_q;
      evicted_q <= 1'b1;
      wb_q      <= pte_rd.modified;
    end
  end

  // result assembly; offset and shifted frame do not overlap
  logic [ADDR_W-1:0]      off_mask;
  logic [ADDR_W-1:0]      pa;
  logic [OUT_TDATA_W-1:0] result;

  assign off_mask = ~({ADDR_W{1'b1}} << page_shift);
  assign pa       = illegal_q ? {ADDR_W{1'b1}}
                              : ((ADDR_W'(frame_q) << page_shift) | (va_q & off_mask));
  assign result   = OUT_TDATA_W'({wb_q, VICTIM_W'(victim_q), evicted_q, fault_q,
                                  illegal_q, pa});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) out_data <= result;
  end

  assign st.illegal    = illegal_q;
  assign st.present    = pres_rd;
  assign st.referenced = pte_rd.referenced;
  assign st.free_avail = next_free < nf;
  assign st.out_busy   = out_valid && !out_ready;

  `MMU_CLK_ASSERT_NOW(a_install_absent, cmd.install, !present[page_q], "install over resident page")
  `MMU_CLK_ASSERT_NOW(a_victim_resident, cmd.sweep_evict, present[own_q], "victim not resident")
  `MMU_CLK_ASSERT_NOW(a_hand_in_range, cmd.sweep_clear || cmd.sweep_evict, FCNT_W'(hand_q) < nf, "hand beyond frame count")
  `MMU_CLK_ASSERT_NOW(a_load_free, cmd.load_out, !out_valid || out_ready, "result register overwritten")
  `MMU_CLK_ASSERT_NEXT(a_alloc_count, cmd.alloc, next_free <= nf, "free counter overran frame count")

endmodule

`default_nettype wire

// ===== hdl/mmu_clock_page_replacement_unit.sv =====
// Top level of the clock (second chance) page replacement unit.
// Depends on mmu_clk_pkg, mmu_clk_ctrl and mmu_clk_dp.
`timescale 1ns / 1ps
`default_nettype none

// Translates one read or write per transaction. The page number is the
// virtual address shifted right by page_shift; a page at or beyond num_pages
// (or 256) returns all ones with the illegal flag. A resident page gets its
// referenced bit set (and modified on a write). An absent page faults: frames
// 0 upward are handed out first, then a clock hand sweeps frames below the
// frame count, clearing referenced bits until it finds an unreferenced page,
// which is evicted (write_back flags a dirty victim). One transaction is in
// flight at a time. After lookup and check, an illegal access or a hit goes
// straight to the result register, a fault taking a free frame installs
// first, and a fault with no free frame sweeps before installing; a sweep
// examines at most frame count + 1 frames. Each examined frame needs two
// dependent registered RAM reads (frame owner at the hand, then the owner's
// page table entry) before its referenced bit is tested. The result sits in
// an output register, so the next input is taken as soon as the sequencer
// returns to idle even while the previous result waits. No clearing pass
// after reset: presence bits are flops cleared by reset.
// Config writes go through cfg_we/cfg_addr/cfg_data: 0 page_shift,
// 1 num_pages, 2 num_frames; write only while the unit is idle.

module mmu_clock_page_replacement_unit
  import mmu_clk_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  // configuration writes
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_addr,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  // access request
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [ADDR_W-1:0]      s_axis_tdata,   // [31:0] virtual_address
  input  wire logic                   s_axis_tuser,   // [0] func (0 read, 1 write)
  // translation result
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // [31:0] physical_address, [32] illegal, [33] page_fault, [34] evicted,
  // [42:35] victim_page, [43] write_back, [47:44] zero
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

  mmu_cmd_t    cmd;
  mmu_status_t st;

  mmu_clk_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .st       (st),
    .cmd      (cmd)
  );

  mmu_clk_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .in_func   (s_axis_tuser),
    .in_va     (s_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for mmu_clock_page_replacement_unit.
// Predicts every translation with a local page-table and clock-hand model.
// Depends on mmu_clk_pkg and the unit's RTL.
`timescale 1ns / 1ps

module tb;
  import mmu_clk_pkg::*;

  // func field of an access transaction
  typedef enum logic {
    ACC_READ  = 1'b0,
    ACC_WRITE = 1'b1
  } access_kind_e;

  // result transaction as laid out on m_axis_tdata, lowest field last
  typedef struct packed {
    logic [3:0]  pad;
    logic        write_back;
    logic [7:0]  victim_page;
    logic        evicted;
    logic        page_fault;
    logic        illegal;
    logic [31:0] physical_address;
  } xlat_result_t;

  typedef struct {
    bit          present;
    bit          referenced;
    bit          modified;
    int unsigned frame;
  } page_entry_t;

  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned PHASE_ITEMS = 60;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [ADDR_W-1:0]     s_axis_tdata = '0;   // [31:0] virtual_address
  logic                  s_axis_tuser = 1'b0; // [0] func
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [31:0] physical_address, [32] illegal, [33] page_fault, [34] evicted,
  // [42:35] victim_page, [43] write_back
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  mmu_clock_page_replacement_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // Translation model: its own copy of config, page table, owners, hand
  // ---------------------------------------------------------------------
  logic [4:0]   cur_shift;
  logic [8:0]   cur_pages;
  logic [6:0]   cur_frames;
  page_entry_t  page_map [MAX_PAGES];
  int unsigned  frame_holder [MAX_FRAMES];
  int unsigned  next_unused_frame;
  int unsigned  sweep_hand;

  xlat_result_t pending_xlat[$];  // translations still owed by the unit
  int unsigned  error_count = 0;
  bit           idle_on = 1'b1;   // random bubbles on both sides
  int unsigned  stall_cycles = 0;

  function automatic int unsigned page_limit();
    return (cur_pages > MAX_PAGES) ? MAX_PAGES : cur_pages;
  endfunction

  // zero frames behaves as one; above the RAM size it saturates
  function automatic int unsigned frame_pool();
    if (cur_frames == 0) return 1;
    return (cur_frames > MAX_FRAMES) ? MAX_FRAMES : cur_frames;
  endfunction

  function automatic void reset_translation_model();
    cur_shift  = PAGE_SHIFT_RST;
    cur_pages  = NUM_PAGES_RST;
    cur_frames = NUM_FRAMES_RST;
    foreach (page_map[i]) page_map[i] = '{0, 0, 0, 0};
    foreach (frame_holder[i]) frame_holder[i] = 0;
    next_unused_frame = 0;
    sweep_hand = 0;
  endfunction

  function automatic xlat_result_t predict_translation(access_kind_e kind,
                                                       logic [31:0] va);
    xlat_result_t r;
    logic [63:0]  page;
    logic [63:0]  offset;
    logic [63:0]  phys;
    int unsigned  nf;
    int unsigned  frame;
    int unsigned  f;
    int unsigned  owner;
    int unsigned  p;
    bit           found;
    r      = '0;
    page   = {32'b0, va} >> cur_shift;
    offset = {32'b0, va} & ((64'd1 << cur_shift) - 64'd1);
    nf     = frame_pool();
    if (page >= page_limit()) begin
      // illegal: all ones, no state touched
      r.physical_address = '1;
      r.illegal = 1'b1;
      return r;
    end
    p = page[31:0];
    if (!page_map[p].present) begin
      r.page_fault = 1'b1;
      if (next_unused_frame < nf) begin
        frame = next_unused_frame;
        next_unused_frame++;
      end else begin
        // second chance sweep over frames below the current pool size
        if (sweep_hand >= nf) sweep_hand = 0;
        found = 1'b0;
        while (!found) begin
          f = sweep_hand;
          owner = frame_holder[f] % MAX_PAGES;
          sweep_hand = (f + 1 >= nf) ? 0 : f + 1;
          if (!page_map[owner].referenced) begin
            found = 1'b1;
            frame = f;
          end else begin
            page_map[owner].referenced = 1'b0;
          end
        end
        r.evicted     = 1'b1;
        r.victim_page = owner[7:0];
        r.write_back  = page_map[owner].modified;
        page_map[owner].present = 1'b0;
      end
      page_map[p].present  = 1'b1;
      page_map[p].modified = 1'b0;
      page_map[p].frame    = frame;
      frame_holder[frame]  = p;
    end
    page_map[p].referenced = 1'b1;
    if (kind == ACC_WRITE) page_map[p].modified = 1'b1;
    phys = (64'(page_map[p].frame) << cur_shift) + offset;
    r.physical_address = phys[31:0];  // wraps to 32 bits
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Result side: random backpressure plus in-order field compare
  // ---------------------------------------------------------------------
  function automatic void check_field(string name, logic [31:0] exp_val,
                                      logic [31:0] got_val);
    if (exp_val !== got_val) begin
      $error("%s: expected %0h, got %0h", name, exp_val, got_val);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    xlat_result_t exp_r;
    xlat_result_t got_r;
    if (m_axis_tvalid && m_axis_tready) begin
      got_r = m_axis_tdata;
      if (pending_xlat.size() == 0) begin
        $error("result transaction with no access outstanding: %0h", m_axis_tdata);
        error_count++;
      end else begin
        exp_r = pending_xlat.pop_front();
        check_field("physical_address", exp_r.physical_address,
                    got_r.physical_address);
        check_field("illegal", 32'(exp_r.illegal), 32'(got_r.illegal));
        check_field("page_fault", 32'(exp_r.page_fault), 32'(got_r.page_fault));
        check_field("evicted", 32'(exp_r.evicted), 32'(got_r.evicted));
        check_field("victim_page", 32'(exp_r.victim_page),
                    32'(got_r.victim_page));
        check_field("write_back", 32'(exp_r.write_back), 32'(got_r.write_back));
      end
    end
    m_axis_tready <= !rst && (!idle_on || $urandom_range(99) >= 19);
  end

  // watchdog: too long without any transaction on either side
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Access side
  // ---------------------------------------------------------------------
  // tvalid stays high from one access to the next unless a bubble is taken
  task automatic send_access(input access_kind_e kind, input logic [31:0] va);
    if (idle_on) begin
      while ($urandom_range(99) < 19) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    pending_xlat.push_back(predict_translation(kind, va));
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= va;
    s_axis_tuser  <= kind;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // drain every outstanding translation, then write all three registers
  task automatic program_unit(input logic [4:0] shift, input logic [8:0] pages,
                              input logic [6:0] frames);
    s_axis_tvalid <= 1'b0;
    while (pending_xlat.size() != 0) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= CFG_PAGE_SHIFT;
    cfg_data <= CFG_DATA_W'(shift);
    @(posedge clk);
    cfg_addr <= CFG_NUM_PAGES;
    cfg_data <= pages;
    @(posedge clk);
    cfg_addr <= CFG_NUM_FRAMES;
    cfg_data <= CFG_DATA_W'(frames);
    @(posedge clk);
    cfg_we     <= 1'b0;
    cur_shift  = shift;
    cur_pages  = pages;
    cur_frames = frames;
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  // reset config: first faults, hits, top legal page, illegal pages
  task automatic test_basic_translation();
    program_unit(PAGE_SHIFT_RST, NUM_PAGES_RST, NUM_FRAMES_RST);
    send_access(ACC_READ,  32'h0000_0000);
    send_access(ACC_WRITE, 32'h0000_0FFF);
    send_access(ACC_WRITE, 32'h000F_FFFF);
    send_access(ACC_READ,  32'h0010_0000);
    send_access(ACC_READ,  32'hFFFF_FFFF);
    send_access(ACC_READ,  32'h0000_1234);
  endtask

  // zero pages, saturation above 256, single legal page
  task automatic test_page_limit();
    program_unit(5'd12, 9'd0, 7'd64);
    send_access(ACC_READ,  32'h0000_0000);
    send_access(ACC_WRITE, 32'h0000_0000);
    program_unit(5'd12, 9'd511, 7'd64);
    send_access(ACC_READ,  32'h000F_F000);
    send_access(ACC_READ,  32'h0010_0000);
    program_unit(5'd12, 9'd1, 7'd64);
    send_access(ACC_READ,  32'h0000_0ABC);
    send_access(ACC_WRITE, 32'h0000_1000);
  endtask

  // frame pool shrunk to zero (acts as one) with dirty victims, pages in
  // frames beyond the pool staying resident, then pool above the maximum
  task automatic test_frame_count();
    program_unit(5'd12, 9'd256, 7'd0);
    send_access(ACC_WRITE, 32'h0000_5000);
    send_access(ACC_READ,  32'h0000_6000);
    send_access(ACC_READ,  32'h000F_F010);
    program_unit(5'd12, 9'd256, 7'd127);
    send_access(ACC_READ,  32'h0000_7000);
  endtask

  // largest and smallest page sizes; physical address wraps at 32 bits
  task automatic test_wide_address();
    program_unit(5'd31, 9'd256, 7'd64);
    send_access(ACC_WRITE, 32'hFFFF_FFFF);
    send_access(ACC_READ,  32'h0000_0000);
    program_unit(5'd0, 9'd256, 7'd64);
    send_access(ACC_READ,  32'h0000_00FF);
    send_access(ACC_READ,  32'h0000_0100);
  endtask

  // mostly a working set about 1.5x the frame pool (hits, faults, evictions),
  // some accesses just past the page limit, some fully random addresses
  task automatic run_mixed_traffic(input int unsigned n_items);
    int unsigned limit;
    int unsigned ws;
    int unsigned base;
    int unsigned page;
    int unsigned roll;
    logic [31:0] offset_mask;
    logic [31:0] va;
    limit = page_limit();
    ws = frame_pool() + frame_pool() / 2 + 2;
    if (ws > limit) ws = limit;
    base = (limit > ws) ? $urandom_range(limit - ws) : 0;
    offset_mask = 32'((64'd1 << cur_shift) - 64'd1);
    repeat (n_items) begin
      roll = $urandom_range(99);
      if (roll < 10) begin
        va = $urandom;
      end else begin
        if (roll < 20 || ws == 0) page = limit + $urandom_range(3);
        else page = base + $urandom_range(ws - 1);
        va = (32'(page) << cur_shift) | ($urandom & offset_mask);
      end
      send_access(access_kind_e'($urandom_range(1)), va);
    end
  endtask

  task automatic test_random_traffic();
    logic [4:0] shift_tab [6] = '{5'd0, 5'd31, 5'd20, 5'd12, 5'd4, 5'd7};
    logic [8:0] pages_tab [6] = '{9'd256, 9'd2, 9'd511, 9'd256, 9'd100, 9'd300};
    logic [6:0] frames_tab [6] = '{7'd64, 7'd1, 7'd8, 7'd64, 7'd0, 7'd127};
    for (int ph = 0; ph < 12; ph++) begin
      if (ph < 6)
        program_unit(shift_tab[ph], pages_tab[ph], frames_tab[ph]);
      else
        program_unit(5'($urandom_range(31)), 9'($urandom_range(511)),
                     7'($urandom_range(127)));
      idle_on = (ph != 3);  // one phase at full rate on both sides
      run_mixed_traffic(PHASE_ITEMS);
    end
    idle_on = 1'b1;
  endtask

  initial begin
    reset_translation_model();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_basic_translation();
    test_page_limit();
    test_frame_count();
    test_wide_address();
    test_random_traffic();
    s_axis_tvalid <= 1'b0;
    while (pending_xlat.size() != 0) @(posedge clk);
    // catch any stray result after the last expected one
    repeat (20) @(posedge clk);
    if (error_count == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule
